@@ hw/rtl/bounded_deque_engine_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the bounded deque engine checks
// Every macro expects a clock named clock in scope; the first two also a reset named reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_ENGINE_CORE_MACROS_SVH
`define BOUNDED_DEQUE_ENGINE_CORE_MACROS_SVH

// Check that cons holds in the same cycle as ante, outside reset
`define BDQ_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bdq check failed");

// Check that cons holds in the cycle after ante, outside reset
`define BDQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bdq check failed");

// Check that cons holds in the cycle after ante, reset included
`define BDQ_ASSERT_ALWAYS_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("bdq check failed");

`endif

@@ hw/rtl/bdq_pkg.sv @@
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants of the bounded deque engine.
// ----------------------------------------------------------------------------
package bdq_pkg;

   // Number of cells in the storage chain
   localparam int MAX_DEPTH = 128;

   // Field widths
   localparam int ITEM_W   = 32;
   localparam int ACTION_W = 3;
   localparam int STATUS_W = 2;
   localparam int CAP_W    = 8;
   localparam int FILL_W   = 8;

   // Item count must hold the full depth itself
   localparam int CNT_W = $clog2(MAX_DEPTH + 1);
   // Width that holds both a count and a capacity for comparison
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   typedef logic signed [ITEM_W-1:0] item_type;
   typedef logic [CNT_W-1:0]         count_type;
   typedef logic [CAP_W-1:0]         cap_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT_RIGHT  = 3'd0,
      ACT_INSERT_LEFT   = 3'd1,
      ACT_EXTRACT_LEFT  = 3'd2,
      ACT_EXTRACT_RIGHT = 3'd3,
      ACT_GET_INFO      = 3'd4
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_UNINIT = 2'd1,
      ST_FULL   = 2'd2,
      ST_EMPTY  = 2'd3
   } status_type;

   // Per-cell control: load the new item, take the left or the right neighbor
   typedef struct packed {
      logic load;
      logic shift_right;
      logic shift_left;
   } cell_ctl_type;

   // Chain-wide control from the sequencing logic
   typedef struct packed {
      logic insert_tail;
      logic shift_right;
      logic shift_left;
   } chain_ctl_type;

endpackage

@@ hw/rtl/bdq_if.sv @@
// ----------------------------------------------------------------------------
// bdq_if
// Valid/ready channel interfaces of the bounded deque engine.
// ----------------------------------------------------------------------------

// Request channel: one deque operation per transfer
interface bdq_req_if;
   logic                            valid;
   logic                            ready;
   logic [bdq_pkg::ACTION_W-1:0]    action;
   logic signed [bdq_pkg::ITEM_W-1:0] item_value;

   modport source (output valid, output action, output item_value, input ready);
   modport sink   (input valid, input action, input item_value, output ready);
endinterface

// Response channel: one result per request
interface bdq_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [bdq_pkg::STATUS_W-1:0]      status;
   logic signed [bdq_pkg::ITEM_W-1:0] extracted_value;
   logic [bdq_pkg::FILL_W-1:0]        fill_count;
   logic [bdq_pkg::CAP_W-1:0]         capacity_echo;

   modport source (output valid, output status, output extracted_value,
                   output fill_count, output capacity_echo, input ready);
   modport sink   (input valid, input status, input extracted_value,
                   input fill_count, input capacity_echo, output ready);
endinterface

// Capacity register write channel
interface bdq_csr_if;
   logic                       valid;
   logic                       ready;
   logic [bdq_pkg::CAP_W-1:0]  capacity;

   modport source (output valid, output capacity, input ready);
   modport sink   (input valid, input capacity, output ready);
endinterface

@@ hw/rtl/bounded_deque_engine_core.sv @@
// ----------------------------------------------------------------------------
// bounded_deque_engine_core
// Bounded double-ended queue of signed 32-bit items on a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   csr_chan writes the capacity (0 to 255; at most 128 items are held).
//   Every write empties the queue; a capacity of zero leaves it unset, and
//   each request then answers with status "not initialized".
//   req_chan carries one operation per transfer: insert right, insert left,
//   extract left, extract right or get info (codes 5 to 7 act as get info).
//   rsp_chan returns exactly one result per request: status, extracted
//   value, item count after the operation and the capacity register.
// Timing:
//   A result appears in the cycle after its request transfer. One request is
//   taken per cycle unless a result is stalled; every operation finishes in
//   the cycle of its transfer. The output register sets the latency.
// Reset and stall:
//   Reset clears the capacity and the item count; the queue is then unset.
//   While a result waits in the output register and rsp_chan.ready is low,
//   req_chan.ready stays low; when the result is taken, a new request is
//   taken in the same cycle.
// ----------------------------------------------------------------------------
module bounded_deque_engine_core (
   input logic         clock,
   input logic         reset,
   bdq_req_if.sink     req_chan,
   bdq_rsp_if.source   rsp_chan,
   bdq_csr_if.sink     csr_chan
);

   // Control and status registers
   bdq_pkg::cap_type   cap_ff;
   bdq_pkg::cap_type   cap_in;
   bdq_pkg::count_type count_ff;
   bdq_pkg::count_type count_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;

   // Response payload registers
   bdq_pkg::status_type status_ff;
   bdq_pkg::status_type status_in;
   bdq_pkg::item_type   value_ff;
   bdq_pkg::item_type   value_in;
   logic [bdq_pkg::FILL_W-1:0] fill_ff;
   logic [bdq_pkg::FILL_W-1:0] fill_in;
   bdq_pkg::cap_type    cap_echo_ff;
   bdq_pkg::cap_type    cap_echo_in;

   // Operation decode
   logic                   req_xfer;
   logic                   csr_xfer;
   logic                   is_full;
   logic                   is_empty;
   bdq_pkg::action_type    action;
   bdq_pkg::status_type    op_status;
   bdq_pkg::item_type      op_value;
   bdq_pkg::count_type     op_count;
   bdq_pkg::chain_ctl_type op_ctl;
   bdq_pkg::chain_ctl_type chain_ctl;
   bdq_pkg::item_type      head_item;
   bdq_pkg::item_type      tail_item;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign csr_xfer       = csr_chan.valid && csr_chan.ready;

   assign action = bdq_pkg::action_type'(req_chan.action);

   // Full when the count reaches the capacity or the chain length
   assign is_full  = (count_ff == bdq_pkg::CNT_W'(bdq_pkg::MAX_DEPTH)) ||
                     (bdq_pkg::CMP_W'(count_ff) >= bdq_pkg::CMP_W'(cap_ff));
   assign is_empty = (count_ff == '0);

   // Decode the request against the current fill state
   always_comb begin
      op_status = bdq_pkg::ST_OK;
      op_value  = '0;
      op_count  = count_ff;
      op_ctl    = '0;
      if (cap_ff == '0) begin
         op_status = bdq_pkg::ST_UNINIT;
      end else begin
         unique case (action)
            bdq_pkg::ACT_INSERT_RIGHT: begin
               if (is_full) begin
                  op_status = bdq_pkg::ST_FULL;
               end else begin
                  op_ctl.insert_tail = 1'b1;
                  op_count           = count_ff + 1'b1;
               end
            end
            bdq_pkg::ACT_INSERT_LEFT: begin
               if (is_full) begin
                  op_status = bdq_pkg::ST_FULL;
               end else begin
                  op_ctl.shift_right = 1'b1;
                  op_count           = count_ff + 1'b1;
               end
            end
            bdq_pkg::ACT_EXTRACT_LEFT: begin
               if (is_empty) begin
                  op_status = bdq_pkg::ST_EMPTY;
               end else begin
                  op_value          = head_item;
                  op_ctl.shift_left = 1'b1;
                  op_count          = count_ff - 1'b1;
               end
            end
            bdq_pkg::ACT_EXTRACT_RIGHT: begin
               if (is_empty) begin
                  op_status = bdq_pkg::ST_EMPTY;
               end else begin
                  op_value = tail_item;
                  op_count = count_ff - 1'b1;
               end
            end
            default: begin
               // Get info and unused codes: report only
               op_status = bdq_pkg::ST_OK;
            end
         endcase
      end
   end

   // Move the chain only on a request transfer
   assign chain_ctl = req_xfer ? op_ctl : '0;

   bdq_chain u_chain (
      .clock     (clock),
      .ctl       (chain_ctl),
      .count     (count_ff),
      .new_item  (req_chan.item_value),
      .head_item (head_item),
      .tail_item (tail_item)
   );

   // Update capacity and count; a capacity write empties the queue
   always_comb begin
      cap_in   = cap_ff;
      count_in = count_ff;
      if (csr_xfer) begin
         cap_in   = csr_chan.capacity;
         count_in = '0;
      end else if (req_xfer) begin
         count_in = op_count;
      end
   end

   // Hold the result until the receiver takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      status_in    = status_ff;
      value_in     = value_ff;
      fill_in      = fill_ff;
      cap_echo_in  = cap_echo_ff;
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
         status_in    = op_status;
         value_in     = op_value;
         fill_in      = bdq_pkg::FILL_W'(op_count);
         cap_echo_in  = cap_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      value_ff    <= value_in;
      fill_ff     <= fill_in;
      cap_echo_ff <= cap_echo_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status          = status_ff;
   assign rsp_chan.extracted_value = value_ff;
   assign rsp_chan.fill_count      = fill_ff;
   assign rsp_chan.capacity_echo   = cap_echo_ff;

endmodule

@@ hw/rtl/bdq_cell.sv @@
// ----------------------------------------------------------------------------
// bdq_cell
// One storage cell of the deque chain: holds an item, loads or shifts.
// ----------------------------------------------------------------------------
module bdq_cell (
   input  logic                  clock,
   input  bdq_pkg::cell_ctl_type ctl,
   input  bdq_pkg::item_type     left_data,
   input  bdq_pkg::item_type     right_data,
   input  bdq_pkg::item_type     new_data,
   output bdq_pkg::item_type     data
);

   bdq_pkg::item_type data_ff;
   bdq_pkg::item_type data_in;

   // Select the next content: load, take a neighbor, or hold
   always_comb begin
      priority if (ctl.load) begin
         data_in = new_data;
      end else if (ctl.shift_right) begin
         data_in = left_data;
      end else if (ctl.shift_left) begin
         data_in = right_data;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

@@ hw/rtl/bdq_chain.sv @@
// ----------------------------------------------------------------------------
// bdq_chain
// Row of storage cells, leftmost item in cell zero, with head and tail taps.
// ----------------------------------------------------------------------------
module bdq_chain (
   input  logic                   clock,
   input  bdq_pkg::chain_ctl_type ctl,
   input  bdq_pkg::count_type     count,
   input  bdq_pkg::item_type      new_item,
   output bdq_pkg::item_type      head_item,
   output bdq_pkg::item_type      tail_item
);

   localparam int LAST = bdq_pkg::MAX_DEPTH - 1;

   bdq_pkg::item_type cell_data   [bdq_pkg::MAX_DEPTH];
   bdq_pkg::item_type tail_masked [bdq_pkg::MAX_DEPTH];

   for (genvar i = 0; i < bdq_pkg::MAX_DEPTH; i++) begin : g_cell
      bdq_pkg::cell_ctl_type cell_ctl;
      bdq_pkg::item_type     left_data;
      bdq_pkg::item_type     right_data;

      // Load the new item into the first free cell on a right insert
      assign cell_ctl.load        = ctl.insert_tail &&
                                    (count == bdq_pkg::CNT_W'(i));
      assign cell_ctl.shift_right = ctl.shift_right;
      assign cell_ctl.shift_left  = ctl.shift_left;

      // Cell zero takes the new item when the chain moves right
      if (i == 0) begin : g_left_end
         assign left_data = new_item;
      end else begin : g_left_inner
         assign left_data = cell_data[i-1];
      end

      // Last cell keeps its own content when the chain moves left
      if (i == LAST) begin : g_right_end
         assign right_data = cell_data[i];
      end else begin : g_right_inner
         assign right_data = cell_data[i+1];
      end

      bdq_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .left_data  (left_data),
         .right_data (right_data),
         .new_data   (new_item),
         .data       (cell_data[i])
      );

      // Mask every cell but the rightmost occupied one
      assign tail_masked[i] = (count == bdq_pkg::CNT_W'(i + 1)) ? cell_data[i] : '0;
   end

   // Merge the one-hot tail taps
   always_comb begin
      tail_item = '0;
      for (int k = 0; k < bdq_pkg::MAX_DEPTH; k++) begin
         tail_item = tail_item | tail_masked[k];
      end
   end

   assign head_item = cell_data[0];

endmodule

@@ hw/rtl/bdq_checker.sv @@
// ----------------------------------------------------------------------------
// bdq_checker
// Port-level checks of the bounded deque engine, bound to its top level.
// ----------------------------------------------------------------------------
`include "bounded_deque_engine_core_macros.svh"

module bdq_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [bdq_pkg::STATUS_W-1:0]   rsp_status,
   input logic [bdq_pkg::FILL_W-1:0]     rsp_fill_count,
   input logic [bdq_pkg::CAP_W-1:0]      rsp_capacity_echo
);

   // Response is empty after reset
   `BDQ_ASSERT_ALWAYS_NEXT(a_rsp_idle_after_reset, reset, !rsp_valid)

   // A stalled response stays offered
   `BDQ_ASSERT_NEXT(a_rsp_held_on_stall, rsp_valid && !rsp_ready, rsp_valid)

   // Every request transfer yields a response in the next cycle
   `BDQ_ASSERT_NEXT(a_rsp_follows_req, req_valid && req_ready, rsp_valid)

   // An unset queue reports no items and no capacity
   `BDQ_ASSERT_SAME(a_uninit_report, rsp_valid && (rsp_status == bdq_pkg::ST_UNINIT), (rsp_fill_count == '0) && (rsp_capacity_echo == '0))

   // A successful operation never holds more items than the capacity
   `BDQ_ASSERT_SAME(a_fill_within_cap, rsp_valid && (rsp_status == bdq_pkg::ST_OK), rsp_fill_count <= rsp_capacity_echo)

endmodule

bind bounded_deque_engine_core bdq_checker u_bdq_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_status        (rsp_chan.status),
   .rsp_fill_count    (rsp_chan.fill_count),
   .rsp_capacity_echo (rsp_chan.capacity_echo)
);
